### rtl/core/gemm_pkg.sv
// Shared types and constants for the alpha-beta matrix multiply block.
`default_nettype none
package gemm_pkg;
  localparam int MAX_ROWS_DEF  = 8;
  localparam int MAX_COLS_DEF  = 8;
  localparam int MAX_INNER_DEF = 8;

  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_LOAD_C  = 2'd2;
  localparam logic [1:0] CMD_COMPUTE = 2'd3;

  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_INNER = 3'd2;
  localparam logic [2:0] REG_ALPHA = 3'd3;
  localparam logic [2:0] REG_BETA  = 3'd4;

  localparam int ACC_W = 48;

  // control handed from sequencer to each cell
  typedef struct packed {
    logic start;   // load beta*c into accumulator
    logic step;    // add one product term
  } cell_ctl_t;

  function automatic logic signed [15:0] round_q88(input logic signed [31:0] p);
    logic signed [32:0] q;
    logic signed [24:0] r;
    begin
      q = 33'(p) + 33'sd128;
      r = q[32:8];
      if (r > 25'sd32767) round_q88 = 16'sh7fff;
      else if (r < -25'sd32768) round_q88 = 16'sh8000;
      else round_q88 = r[15:0];
    end
  endfunction
endpackage
`default_nettype wire

### rtl/core/gemm_alpha_beta_colmajor.sv
// Top level of the alpha-beta column-major matrix multiply block.
// A compute runs column by column: per column j it sets each row cell to
// beta*c, issues the inner terms (one inner index per cycle, all m row cells
// in parallel), flushes the B read, scaling and product registers, then
// shifts the column out of the cell chain, which can stall on the output.
// The inner loop is set by the single B read per cycle.
`default_nettype none
module gemm_alpha_beta_colmajor #(
  parameter int MAX_ROWS  = gemm_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = gemm_pkg::MAX_COLS_DEF,
  parameter int MAX_INNER = gemm_pkg::MAX_INNER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // cmd[1:0], row[4:2], col[7:5], value[23:8]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6], zero
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int AW = 3;
  localparam int AC = gemm_pkg::ACC_W;
  localparam logic [2:0] S_IDLE = 3'd0, S_INIT = 3'd1, S_MAC = 3'd2,
                         S_DRAIN = 3'd3, S_OUT = 3'd4;

  logic [3:0] rows_r, cols_r, inner_r;
  logic signed [15:0] alpha_r, beta_r;
  logic signed [15:0] b_mem [MAX_INNER][MAX_COLS];

  logic [2:0] state_r, state_nxt;
  logic [AW-1:0] j_r, l_r, i_r;
  logic [3:0] cnt_r;
  logic [3:0] m, n, k;

  logic [1:0] cmd;
  logic [AW-1:0] irow, icol;
  logic signed [15:0] ival;
  assign cmd = in_tdata[1:0];
  assign irow = in_tdata[4:2];
  assign icol = in_tdata[7:5];
  assign ival = in_tdata[23:8];

  function automatic logic [3:0] clampd(input logic [3:0] v, input int hi);
    if (v == 4'd0) clampd = 4'd1;
    else if (int'(v) > hi) clampd = 4'(hi);
    else clampd = v;
  endfunction
  assign m = clampd(rows_r, MAX_ROWS);
  assign n = clampd(cols_r, MAX_COLS);
  assign k = clampd(inner_r, MAX_INNER);

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 4'd8; cols_r <= 4'd8; inner_r <= 4'd8;
      alpha_r <= 16'sd256; beta_r <= 16'sd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gemm_pkg::REG_ROWS:  rows_r  <= cfg_data[3:0];
        gemm_pkg::REG_COLS:  cols_r  <= cfg_data[3:0];
        gemm_pkg::REG_INNER: inner_r <= cfg_data[3:0];
        gemm_pkg::REG_ALPHA: alpha_r <= cfg_data;
        gemm_pkg::REG_BETA:  beta_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc && cmd == gemm_pkg::CMD_LOAD_B &&
        int'(irow) < MAX_INNER && int'(icol) < MAX_COLS)
      b_mem[irow][icol] <= ival;
  end

  // scaled B term for the current inner index, registered read then product
  logic signed [15:0] b_rd_r;
  logic signed [31:0] ab_r;
  logic signed [15:0] sb;
  always_ff @(posedge clk) begin
    b_rd_r <= b_mem[l_r][j_r];
    ab_r   <= alpha_r * b_rd_r;
  end
  assign sb = gemm_pkg::round_q88(ab_r);

  logic step_p_r, step_d_r;   // sb and a_val valid for inner index l_d_r
  logic [AW-1:0] l_p_r, l_d_r;
  gemm_pkg::cell_ctl_t ctl;
  logic shift;
  logic signed [AC-1:0] chain [MAX_ROWS+1];
  assign chain[MAX_ROWS] = '0;
  assign ctl = gemm_pkg::cell_ctl_t'{start: (state_r == S_INIT), step: step_d_r};
  assign shift = (state_r == S_OUT) && out_tready;

  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_cell
    logic signed [15:0] a_row [MAX_INNER];
    logic signed [15:0] c_row [MAX_COLS];
    logic signed [31:0] initv;
    always_ff @(posedge clk) begin
      if (in_acc && int'(irow) == r) begin
        if (cmd == gemm_pkg::CMD_LOAD_A && int'(icol) < MAX_INNER) a_row[icol] <= ival;
        if (cmd == gemm_pkg::CMD_LOAD_C && int'(icol) < MAX_COLS) c_row[icol] <= ival;
      end
    end
    assign initv = c_row[j_r] * beta_r;
    gemm_cell u_cell (
      .clk(clk), .ctl(ctl), .shift(shift), .init_val(initv),
      .a_val(a_row[l_d_r]), .sb_val(sb),
      .acc_in(chain[r+1]), .acc_out(chain[r])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && cmd == gemm_pkg::CMD_COMPUTE) state_nxt = S_INIT;
      S_INIT:  state_nxt = S_MAC;
      S_MAC:   if (cnt_r == k) state_nxt = S_DRAIN;
      S_DRAIN: if (cnt_r == 4'd2) state_nxt = S_OUT;
      S_OUT:   if (out_tready && 4'(i_r) == m - 4'd1)
                 state_nxt = (4'(j_r) == n - 4'd1) ? S_IDLE : S_INIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; j_r <= '0; l_r <= '0; i_r <= '0; cnt_r <= '0;
      step_p_r <= 1'b0; step_d_r <= 1'b0; l_p_r <= '0; l_d_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_p_r <= (state_r == S_MAC) && (cnt_r < k);
      step_d_r <= step_p_r;
      l_p_r <= l_r;
      l_d_r <= l_p_r;
      unique case (state_r)
        S_IDLE: begin j_r <= '0; l_r <= '0; cnt_r <= '0; i_r <= '0; end
        S_INIT: begin l_r <= '0; cnt_r <= '0; i_r <= '0; end
        S_MAC: begin
          cnt_r <= (cnt_r == k) ? 4'd0 : cnt_r + 4'd1;
          l_r <= l_r + AW'(1);
        end
        S_DRAIN: cnt_r <= cnt_r + 4'd1;
        S_OUT: if (out_tready) begin
          i_r <= i_r + AW'(1);
          if (4'(i_r) == m - 4'd1) j_r <= j_r + AW'(1);
        end
        default: ;
      endcase
    end
  end

  // S_MAC: cnt c issues the B read for l=c; term l=c is added via b_rd_r, ab_r, prod_r.
  logic signed [AC-1:0] head;
  logic signed [31:0] sat;
  assign head = chain[0];
  always_comb begin
    if (head > AC'(64'sh7fffffff)) sat = 32'sh7fffffff;
    else if (head < -AC'(64'sh80000000)) sat = 32'sh80000000;
    else sat = head[31:0];
  end
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata = {2'b00, sat, j_r, i_r};
  assign out_tlast = (4'(i_r) == m - 4'd1) && (4'(j_r) == n - 4'd1);

`ifndef NO_ASSERTIONS
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while emitting");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(i_r) && $stable(j_r))
    else $error("result moved under stall");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_d_r |-> !out_tvalid) else $error("accumulate during output");
`endif
endmodule
`default_nettype wire

### rtl/core/gemm_cell.sv
// One accumulator cell of the row chain: holds one row's sum, hands it on when shifting.
`default_nettype none
module gemm_cell (
  input  wire logic                         clk,
  input  wire gemm_pkg::cell_ctl_t          ctl,
  input  wire logic                         shift,
  input  wire logic signed [31:0]           init_val,
  input  wire logic signed [15:0]           a_val,
  input  wire logic signed [15:0]           sb_val,
  input  wire logic signed [gemm_pkg::ACC_W-1:0] acc_in,
  output logic signed [gemm_pkg::ACC_W-1:0] acc_out
);
  logic signed [gemm_pkg::ACC_W-1:0] acc_r;
  logic signed [31:0]                prod_r;
  logic                              add_r;

  always_ff @(posedge clk) begin
    prod_r <= a_val * sb_val;
    add_r  <= ctl.step;
    if (shift) acc_r <= acc_in;
    else if (ctl.start) acc_r <= gemm_pkg::ACC_W'(init_val);
    else if (add_r) acc_r <= acc_r + gemm_pkg::ACC_W'(prod_r);
  end
  assign acc_out = acc_r;
endmodule
`default_nettype wire
